/* hw/rtl/bir_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bir_pkg
// Shared constants for the bilinear resize unit and its divider.
// ---------------------------------------------------------------------------
package bir_pkg;

	localparam int MAX_IN_DIM  = 256;
	localparam int MAX_OUT_DIM = 1024;
	localparam int FRAC_BITS   = 8;

	// coordinate and size widths
	localparam int IN_BITS   = $clog2(MAX_IN_DIM);
	localparam int IDIM_W    = IN_BITS + 1;
	localparam int ODIM_W    = $clog2(MAX_OUT_DIM) + 1;
	localparam int COORD_W   = 10;
	localparam int PIX_W     = 16;
	localparam int CFG_W     = 11;

	// divider: (coord * in_dim) << FRAC_BITS over out_dim
	localparam int DVD_W     = COORD_W + IDIM_W + FRAC_BITS;
	localparam int QUO_W     = IN_BITS + FRAC_BITS;
	localparam int DCNT_W    = $clog2(DVD_W + 1);

	// blend weights and accumulator
	localparam int WGT1_W    = FRAC_BITS + 1;
	localparam int WGT_W     = 2 * FRAC_BITS + 1;
	localparam int ACC_W     = PIX_W + 2 * FRAC_BITS;
	localparam int ADDR_W    = 2 * IN_BITS;

	// register indexes
	localparam logic [1:0] REG_IN_WIDTH   = 2'd0;
	localparam logic [1:0] REG_IN_HEIGHT  = 2'd1;
	localparam logic [1:0] REG_OUT_WIDTH  = 2'd2;
	localparam logic [1:0] REG_OUT_HEIGHT = 2'd3;

	// item modes
	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_READ  = 1'b1;

endpackage

/* hw/rtl/bir_div.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bir_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module bir_div
	import bir_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [DVD_W-1:0]    dividend,
	input  logic [ODIM_W-1:0]   divisor,
	output logic                done,
	output logic [QUO_W-1:0]    quotient
);

	logic [DVD_W-1:0]  dvd_q;
	logic [ODIM_W-1:0] dsr_q;
	logic [ODIM_W-1:0] rem_q;
	logic [QUO_W-1:0]  quo_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              busy_q;
	logic [ODIM_W:0]   trial;
	logic              fits;

	// trial subtract of the next partial remainder
	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign fits  = (trial >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DCNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DCNT_W'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			rem_q <= fits ? ODIM_W'(trial - {1'b0, dsr_q}) : ODIM_W'(trial);
			quo_q <= {quo_q[QUO_W-2:0], fits};
		end
	end

	assign quotient = quo_q;

`ifndef ASSERT_OFF
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy_q))
		else $error("divider done without work");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && cnt_q > DCNT_W'(1) |=> busy_q)
		else $error("divider stopped early");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held");
`endif

endmodule

/* hw/rtl/bilinear_image_resize_unit.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bilinear_image_resize_unit
// Source frame store with a bilinear resampler.
// ---------------------------------------------------------------------------
// channel   dir  payload
// s_*       in   tuser: mode; tdata: row, col, value
// m_*       out  tuser: out_of_range; tdata: pixel
// cfg_*     in   register index and write data
//
// a write item writes the frame memory directly
// a read item runs from the accept through the divider steps, one bit a cycle
// and one step per dividend bit, the done strobe, the weight step, four memory
// reads through the read pipeline and the push, up to the next accept
// an out-of-range read skips the divider and goes straight to its push
// frame memory is not cleared at reset
// a waiting result stalls only the next read, in its push cycle
module bilinear_image_resize_unit
	import bir_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [39:0]       s_tdata,   // row, col, value, zero pad
	input  logic              s_tuser,   // mode
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [15:0]       m_tdata,   // pixel
	output logic              m_tuser,   // out_of_range
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [CFG_W-1:0]  cfg_wdata
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIV  = 3'd1;
	localparam logic [2:0] S_WGT  = 3'd2;
	localparam logic [2:0] S_RD   = 3'd3;
	localparam logic [2:0] S_PUSH = 3'd4;

	logic [2:0]          st_q;
	logic [IDIM_W-1:0]   in_w_q, in_h_q;
	logic [ODIM_W-1:0]   out_w_q, out_h_q;
	logic [IDIM_W-1:0]   iw, ih;
	logic [ODIM_W-1:0]   ow, oh;
	logic [COORD_W-1:0]  row, col;
	logic [PIX_W-1:0]    value;
	logic                acc_in, div_go;
	logic [DVD_W-1:0]    dvd_x, dvd_y;
	logic                dx_done, dy_done;
	logic [QUO_W-1:0]    sx, sy;
	logic [WGT_W-1:0]    w_q [4];
	logic [2:0]          cnt_q;
	logic [IN_BITS:0]    nx, ny;
	logic                nb_ok;
	logic [PIX_W-1:0]    mem [2**ADDR_W];
	logic [PIX_W-1:0]    rdata_s1;
	logic                v_s1, ok_s1, v_s2;
	logic [1:0]          idx_s1;
	logic [ACC_W-1:0]    prod_s2, acc_q;
	logic                oor_q;
	logic                out_free;

	// effective sizes, clamped to the legal range
	always_comb begin
		iw = (in_w_q == '0) ? IDIM_W'(1) :
			(in_w_q > IDIM_W'(MAX_IN_DIM)) ? IDIM_W'(MAX_IN_DIM) : in_w_q;
		ih = (in_h_q == '0) ? IDIM_W'(1) :
			(in_h_q > IDIM_W'(MAX_IN_DIM)) ? IDIM_W'(MAX_IN_DIM) : in_h_q;
		ow = (out_w_q == '0) ? ODIM_W'(1) :
			(out_w_q > ODIM_W'(MAX_OUT_DIM)) ? ODIM_W'(MAX_OUT_DIM) : out_w_q;
		oh = (out_h_q == '0) ? ODIM_W'(1) :
			(out_h_q > ODIM_W'(MAX_OUT_DIM)) ? ODIM_W'(MAX_OUT_DIM) : out_h_q;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_w_q  <= IDIM_W'(256);
			in_h_q  <= IDIM_W'(256);
			out_w_q <= ODIM_W'(256);
			out_h_q <= ODIM_W'(256);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IN_WIDTH:   in_w_q  <= cfg_wdata[IDIM_W-1:0];
				REG_IN_HEIGHT:  in_h_q  <= cfg_wdata[IDIM_W-1:0];
				REG_OUT_WIDTH:  out_w_q <= cfg_wdata[ODIM_W-1:0];
				REG_OUT_HEIGHT: out_h_q <= cfg_wdata[ODIM_W-1:0];
				default: ;
			endcase
		end
	end

	// input unpacking and handshake
	assign row      = s_tdata[9:0];
	assign col      = s_tdata[19:10];
	assign value    = s_tdata[35:20];
	assign s_tready = (st_q == S_IDLE);
	assign acc_in   = s_tvalid && s_tready;
	assign div_go   = acc_in && (s_tuser == MODE_READ)
		&& ({1'b0, row} < oh) && ({1'b0, col} < ow);
	assign out_free = !m_tvalid || m_tready;

	// scaled coordinates into the dividers
	assign dvd_x = {DVD_W'(col * iw)} << FRAC_BITS;
	assign dvd_y = {DVD_W'(row * ih)} << FRAC_BITS;

	bir_div u_div_x (
		.clk(clk), .arst_n(arst_n), .start(div_go),
		.dividend(dvd_x), .divisor(ow), .done(dx_done), .quotient(sx)
	);

	bir_div u_div_y (
		.clk(clk), .arst_n(arst_n), .start(div_go),
		.dividend(dvd_y), .divisor(oh), .done(dy_done), .quotient(sy)
	);

	// neighbour for the current read slot
	assign nx    = {1'b0, sx[QUO_W-1:FRAC_BITS]} + (IN_BITS+1)'(cnt_q[0]);
	assign ny    = {1'b0, sy[QUO_W-1:FRAC_BITS]} + (IN_BITS+1)'(cnt_q[1]);
	assign nb_ok = ({1'b0, nx} < {1'b0, iw}) && ({1'b0, ny} < {1'b0, ih});

	// frame memory: write on an in-range write item, one read a cycle while blending
	always_ff @(posedge clk) begin
		if (acc_in && s_tuser == MODE_WRITE && row < COORD_W'(ih)
				&& col < COORD_W'(iw))
			mem[{row[IN_BITS-1:0], col[IN_BITS-1:0]}] <= value;
		if (st_q == S_RD && !cnt_q[2])
			rdata_s1 <= mem[{ny[IN_BITS-1:0], nx[IN_BITS-1:0]}];
	end

	// control sequencer and blend pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_IDLE;
			cnt_q    <= '0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			m_tvalid <= 1'b0;
			oor_q    <= 1'b0;
		end else begin
			if (m_tvalid && m_tready && st_q != S_PUSH)
				m_tvalid <= 1'b0;
			v_s1 <= (st_q == S_RD) && !cnt_q[2];
			v_s2 <= v_s1;
			case (st_q)
				S_IDLE: begin
					if (acc_in && s_tuser == MODE_READ) begin
						oor_q <= !div_go;
						st_q  <= div_go ? S_DIV : S_PUSH;
					end
				end
				S_DIV: begin
					if (dx_done)
						st_q <= S_WGT;
				end
				S_WGT: begin
					cnt_q <= '0;
					st_q  <= S_RD;
				end
				S_RD: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 3'd5)
						st_q <= S_PUSH;
				end
				S_PUSH: begin
					if (out_free) begin
						m_tvalid <= 1'b1;
						st_q     <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// weights, products, accumulation and result
	always_ff @(posedge clk) begin
		if (st_q == S_WGT) begin
			w_q[0] <= WGT_W'((WGT1_W'(1 << FRAC_BITS) - sx[FRAC_BITS-1:0])
				* (WGT1_W'(1 << FRAC_BITS) - sy[FRAC_BITS-1:0]));
			w_q[1] <= WGT_W'({1'b0, sx[FRAC_BITS-1:0]}
				* (WGT1_W'(1 << FRAC_BITS) - sy[FRAC_BITS-1:0]));
			w_q[2] <= WGT_W'((WGT1_W'(1 << FRAC_BITS) - sx[FRAC_BITS-1:0])
				* {1'b0, sy[FRAC_BITS-1:0]});
			w_q[3] <= WGT_W'({1'b0, sx[FRAC_BITS-1:0]} * {1'b0, sy[FRAC_BITS-1:0]});
			acc_q  <= '0;
		end
		if (st_q == S_RD) begin
			ok_s1  <= nb_ok;
			idx_s1 <= cnt_q[1:0];
		end
		prod_s2 <= ACC_W'((ok_s1 ? rdata_s1 : '0) * w_q[idx_s1]);
		if (v_s2)
			acc_q <= acc_q + prod_s2;
		if (st_q == S_PUSH && out_free) begin
			m_tdata <= oor_q ? '0 : acc_q[ACC_W-1:2*FRAC_BITS];
			m_tuser <= oor_q;
		end
	end

`ifndef ASSERT_OFF
	a_div_pair: assert property (@(posedge clk) disable iff (!arst_n)
		dx_done == dy_done)
		else $error("coordinate dividers out of step");
	a_div_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		dx_done |-> st_q == S_DIV)
		else $error("divider finished outside divide state");
	a_blend_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> st_q == S_RD || st_q == S_PUSH)
		else $error("blend product outside read phase");
	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_PUSH && !m_tvalid |=> m_tvalid && st_q == S_IDLE)
		else $error("free output not filled");
`endif

endmodule

/* tb/sv/bilinear_image_resize_unit_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bilinear_image_resize_unit_tb
// Self-checking bench for the bilinear resize unit. Fills part of the source
// frame, issues output pixel requests and checks every returned pixel against
// a fixed-point bilinear predictor, over several size settings and handshake
// idling mixes. Reads only touch source pixels that were written before.
// ---------------------------------------------------------------------------
module bilinear_image_resize_unit_tb;
	import bir_pkg::*;

	typedef struct {
		logic        mode;
		logic [9:0]  row;
		logic [9:0]  col;
		logic [15:0] value;
	} pix_req_t;

	typedef struct {
		logic [15:0] pixel;
		logic        oor;
	} pix_res_t;

	localparam int IDLE_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 60;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [39:0]       s_tdata = '0;   // row, col, value, zero pad
	logic              s_tuser = 1'b0; // mode
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [15:0]       m_tdata;        // pixel
	logic              m_tuser;        // out_of_range
	logic              cfg_we = 1'b0;
	logic [1:0]        cfg_index = '0;
	logic [CFG_W-1:0]  cfg_wdata = '0;

	bilinear_image_resize_unit dut (.*);

	pix_req_t    req_q[$];
	pix_res_t    pixel_exp_q[$];
	pix_req_t    cur_req;
	logic [15:0] frame_mem [0:65535];
	bit          src_written [0:65535];
	int          raw_iw = 256, raw_ih = 256, raw_ow = 256, raw_oh = 256;
	int          send_idle_pct = 0, recv_stall_pct = 0;
	int          hold_left = 0;
	int          idle_cycles = 0;
	int          errors = 0;

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int eff_dim(int v, int hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	// source position in fixed point for one output coordinate
	function automatic longint src_pos(int o, int in_dim, int out_dim);
		return ((longint'(o) * in_dim) << FRAC_BITS) / out_dim;
	endfunction

	function automatic bit outside_src(int r, int c);
		return r >= eff_dim(raw_ih, MAX_IN_DIM) || c >= eff_dim(raw_iw, MAX_IN_DIM);
	endfunction

	function automatic longint src_pix(int r, int c);
		if (outside_src(r, c)) return 0;
		return frame_mem[r * MAX_IN_DIM + c];
	endfunction

	// bilinear blend of the four neighbours, truncated
	function automatic pix_res_t resample_pixel(int r, int c);
		pix_res_t res;
		longint sx, sy, fx, fy, one, sum;
		int x0, y0;
		one = longint'(1) << FRAC_BITS;
		if (r >= eff_dim(raw_oh, MAX_OUT_DIM) || c >= eff_dim(raw_ow, MAX_OUT_DIM)) begin
			res.pixel = '0;
			res.oor = 1'b1;
			return res;
		end
		sx = src_pos(c, eff_dim(raw_iw, MAX_IN_DIM), eff_dim(raw_ow, MAX_OUT_DIM));
		sy = src_pos(r, eff_dim(raw_ih, MAX_IN_DIM), eff_dim(raw_oh, MAX_OUT_DIM));
		x0 = int'(sx >> FRAC_BITS);
		y0 = int'(sy >> FRAC_BITS);
		fx = sx & (one - 1);
		fy = sy & (one - 1);
		sum = src_pix(y0, x0) * (one - fx) * (one - fy)
			+ src_pix(y0, x0 + 1) * fx * (one - fy)
			+ src_pix(y0 + 1, x0) * (one - fx) * fy
			+ src_pix(y0 + 1, x0 + 1) * fx * fy;
		res.pixel = 16'(sum >> (2 * FRAC_BITS));
		res.oor = 1'b0;
		return res;
	endfunction

	function automatic bit nb_ok(int r, int c);
		return outside_src(r, c) || src_written[r * MAX_IN_DIM + c];
	endfunction

	// a read may go out only if every neighbour inside the source was written
	function automatic bit read_allowed(int r, int c);
		int x0, y0;
		if (r >= eff_dim(raw_oh, MAX_OUT_DIM) || c >= eff_dim(raw_ow, MAX_OUT_DIM))
			return 1'b1;
		x0 = int'(src_pos(c, eff_dim(raw_iw, MAX_IN_DIM), eff_dim(raw_ow, MAX_OUT_DIM)) >> FRAC_BITS);
		y0 = int'(src_pos(r, eff_dim(raw_ih, MAX_IN_DIM), eff_dim(raw_oh, MAX_OUT_DIM)) >> FRAC_BITS);
		return nb_ok(y0, x0) && nb_ok(y0, x0 + 1) && nb_ok(y0 + 1, x0) && nb_ok(y0 + 1, x0 + 1);
	endfunction

	task automatic push_write(int r, int c, int v);
		pix_req_t q;
		q.mode = MODE_WRITE;
		q.row = 10'(r);
		q.col = 10'(c);
		q.value = 16'(v);
		if (!outside_src(r, c)) src_written[r * MAX_IN_DIM + c] = 1'b1;
		req_q.push_back(q);
	endtask

	task automatic push_read(int r, int c);
		pix_req_t q;
		if (!read_allowed(r, c)) return;
		q.mode = MODE_READ;
		q.row = 10'(r);
		q.col = 10'(c);
		q.value = 16'($urandom);
		req_q.push_back(q);
	endtask

	// sender drives items from the request queue and predicts on acceptance
	always @(posedge clk or negedge arst_n) begin
		pix_req_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				if (cur_req.mode == MODE_WRITE) begin
					if (!outside_src(cur_req.row, cur_req.col))
						frame_mem[cur_req.row * MAX_IN_DIM + cur_req.col] = cur_req.value;
				end else begin
					pixel_exp_q.push_back(resample_pixel(cur_req.row, cur_req.col));
				end
			end
			if (!s_tvalid || s_tready) begin
				if (req_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					nxt = req_q.pop_front();
					cur_req = nxt;
					s_tvalid <= 1'b1;
					s_tdata <= {4'b0, nxt.value, nxt.col, nxt.row};
					s_tuser <= nxt.mode;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver ready, with an optional long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// result checker and watchdog
	always @(posedge clk) begin
		pix_res_t exp_res;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pixel_exp_q.size() == 0) begin
					$error("result with no expectation: pixel %0h oor %0b", m_tdata, m_tuser);
					errors++;
				end else begin
					exp_res = pixel_exp_q.pop_front();
					if (m_tdata !== exp_res.pixel) begin
						$error("pixel mismatch: expected %0h actual %0h", exp_res.pixel, m_tdata);
						errors++;
					end
					if (m_tuser !== exp_res.oor) begin
						$error("out_of_range mismatch: expected %0b actual %0b",
							exp_res.oor, m_tuser);
						errors++;
					end
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	task automatic wait_drained();
		@(posedge clk);
		#1;
		while (req_q.size() > 0 || s_tvalid || pixel_exp_q.size() > 0) begin
			@(posedge clk);
			#1;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(logic [1:0] idx, int v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= CFG_W'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_IN_WIDTH:   raw_iw = v & 'h1FF;
			REG_IN_HEIGHT:  raw_ih = v & 'h1FF;
			REG_OUT_WIDTH:  raw_ow = v & 'h7FF;
			default:        raw_oh = v & 'h7FF;
		endcase
	endtask

	// one setting: sizes, idling, a filled corner of the source, random items
	task automatic run_phase(int iw, int ih, int ow, int oh, int frows, int fcols,
		int sp, int rp, int n_items);
		int ih_e, iw_e, oh_e, ow_e, r, c, pick;
		wait_drained();
		cfg_write(REG_IN_WIDTH, iw);
		cfg_write(REG_IN_HEIGHT, ih);
		cfg_write(REG_OUT_WIDTH, ow);
		cfg_write(REG_OUT_HEIGHT, oh);
		send_idle_pct = sp;
		recv_stall_pct = rp;
		ih_e = eff_dim(raw_ih, MAX_IN_DIM);
		iw_e = eff_dim(raw_iw, MAX_IN_DIM);
		oh_e = eff_dim(raw_oh, MAX_OUT_DIM);
		ow_e = eff_dim(raw_ow, MAX_OUT_DIM);
		for (int i = 0; i < frows && i < ih_e; i++)
			for (int j = 0; j < fcols && j < iw_e; j++)
				push_write(i, j, $urandom);
		for (int k = 0; k < n_items; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				// mostly in range, often near the filled corner
				r = $urandom_range(0, 1) ? $urandom_range(0, (oh_e > 8) ? 7 : oh_e - 1)
					: $urandom_range(0, oh_e - 1);
				c = $urandom_range(0, 1) ? $urandom_range(0, (ow_e > 8) ? 7 : ow_e - 1)
					: $urandom_range(0, ow_e - 1);
				if (pick < 8) begin
					r = $urandom_range(0, 1023);
					c = $urandom_range(0, 1023);
				end
				push_read(r, c);
			end else if (pick < 88) begin
				r = $urandom_range(0, ((frows < ih_e) ? frows : ih_e) - 1);
				c = $urandom_range(0, ((fcols < iw_e) ? fcols : iw_e) - 1);
				push_write(r, c, $urandom);
			end else begin
				// writes that land anywhere, mostly outside the source
				push_write($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom);
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: small frame, extreme values, corners, out-of-range cases
		run_phase(4, 3, 7, 5, 3, 4, 0, 0, 0);
		push_write(0, 0, 'hFFFF);
		push_write(0, 1, 0);
		push_write(2, 3, 'hFFFF);
		push_write(1023, 1023, 'hFFFF);
		push_write(3, 0, 'h1234);
		push_write(0, 4, 'h4321);
		push_read(0, 0);
		push_read(0, 6);
		push_read(4, 0);
		push_read(4, 6);
		push_read(2, 3);
		push_read(1023, 1023);
		push_read(5, 0);
		push_read(0, 7);
		push_read(1, 1);

		// register extremes: values above the maxima and zero
		run_phase(511, 0, 2047, 1, 1, 64, 0, 0, 100);
		run_phase(1, 256, 0, 1024, 64, 1, 47, 0, 100);
		run_phase(256, 256, 256, 256, 4, 16, 0, 47, 100);

		// random small sizes, with a long receiver hold-off
		run_phase($urandom_range(2, 16), $urandom_range(2, 16), $urandom_range(1, 40),
			$urandom_range(1, 40), 16, 16, 6, 6, 150);
		#1;
		hold_left = 400;
		run_phase($urandom_range(1, 12), $urandom_range(1, 12), $urandom_range(1, 64),
			$urandom_range(1, 64), 12, 12, 0, 47, 150);
		run_phase($urandom_range(2, 9), $urandom_range(2, 9), $urandom_range(1, 1024),
			$urandom_range(1, 30), 9, 9, 47, 0, 100);
		run_phase(2, 2, 1024, 1024, 2, 2, 0, 0, 60);

		wait_drained();
		if (pixel_exp_q.size() != 0) begin
			$error("%0d expected results never arrived", pixel_exp_q.size());
			errors++;
		end
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
